// ===== hw/rtl/p2r_pkg.sv =====
// Shared constants and types for the palette-to-RGB24 row expander.
// No dependencies; used by palette_to_rgb24_row_expander_top.
package p2r_pkg;

  localparam int CFG_W     = 13;   // row width register
  localparam int PAL_DEPTH = 256;  // palette entries
  localparam int PAL_AW    = 8;
  localparam int COLOR_W   = 24;
  localparam int BYTE_W    = 8;
  localparam int IN_DATA_W = 40;   // pixel_byte, entry_index, entry_color

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  // Position of each byte within one pixel's run of output bytes
  localparam logic [2:0] POS_BLUE  = 3'd0;
  localparam logic [2:0] POS_GREEN = 3'd1;
  localparam logic [2:0] POS_RED   = 3'd2;

  localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h00;

  // Pixel request waiting on the palette read
  typedef struct packed {
    logic       valid;
    logic [1:0] npad;   // zero pad bytes after this pixel
  } p2r_fetch_t;

endpackage

// ===== hw/rtl/palette_to_rgb24_row_expander_top.sv =====
// Top level of the 8-bpp palette to 24-bpp BGR row expander.
// Depends on p2r_pkg and p2r_ram.

// Usage: stream mode-0 requests (tuser low) to load palette entries, then
// mode-1 requests (tuser high) carrying the 8-bpp pixel-data bytes of the
// image, row pad bytes included; write the image width to cfg before
// either. A pixel yields three output bytes, one per color byte (blue,
// green, red), and the last pixel of a row yields 3 + (width mod 4)
// bytes, with its zero pad bytes; the output rate of one byte per cycle,
// while out_tready is high, sets the throughput. Pixels overlap: a
// palette read stage and a byte emitter stage run together, so the next
// pixel is fetched while the current one drains. tlast marks the final
// byte of each pixel's run and tuser marks pad bytes. Palette entries
// need no clearing after reset; a pixel must only use entries that were
// loaded.
module palette_to_rgb24_row_expander_top #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] pixel_byte, [15:8] entry_index, [39:16] entry_color
  input  logic [39:0] in_tdata,
  // [0] mode
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] out_byte
  output logic [7:0]  out_tdata,
  // [0] is_padding
  output logic        out_tuser,
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int WW = (CW > p2r_pkg::CFG_W) ? CW : p2r_pkg::CFG_W;
  localparam logic [WW-1:0] MAX_W = WW'(MAX_WIDTH);
  localparam logic [WW-1:0] ONE_W = WW'(1);

  // Input fields
  logic [7:0]  pixel_byte;
  logic [7:0]  entry_index;
  logic [23:0] entry_color;
  assign pixel_byte  = in_tdata[7:0];
  assign entry_index = in_tdata[15:8];
  assign entry_color = in_tdata[39:16];

  // Effective width, clamped when written
  logic [WW-1:0] weff_r, weff_nxt, cfg_ext;

  assign cfg_ext = WW'(cfg_wr_data);

  always_comb begin
    weff_nxt = weff_r;
    if (cfg_wr_en) begin
      priority if (cfg_ext == '0) begin
        weff_nxt = ONE_W;
      end else if (cfg_ext > MAX_W) begin
        weff_nxt = MAX_W;
      end else begin
        weff_nxt = cfg_ext;
      end
    end
  end

  // Row state
  logic [CW-1:0] col_r, col_nxt;
  logic [1:0]    pads_r, pads_nxt;
  logic [WW-1:0] col_inc;

  // Pipeline
  p2r_pkg::p2r_fetch_t fetch_r, fetch_nxt;
  logic                em_valid_r, em_valid_nxt;
  logic [2:0]          em_idx_r, em_idx_nxt;
  logic [2:0]          em_last_r, em_last_nxt;
  logic [23:0]         em_color_r, em_color_nxt;

  logic in_acc, out_acc, em_done, em_load;
  logic pal_we, pal_re, row_end;
  logic [23:0] pal_rdata;

  assign out_acc   = out_tvalid && out_tready;
  assign em_done   = out_acc && (em_idx_r == em_last_r);
  assign em_load   = fetch_r.valid && (!em_valid_r || em_done);
  assign in_tready = !fetch_r.valid || em_load;
  assign in_acc    = in_tvalid && in_tready;

  assign pal_we  = in_acc && (in_tuser == p2r_pkg::MODE_LOAD);
  assign pal_re  = in_acc && (in_tuser == p2r_pkg::MODE_PIXEL) && (pads_r == 2'd0);
  assign col_inc = WW'(col_r) + ONE_W;
  assign row_end = col_inc >= weff_r;

  p2r_ram #(
    .WIDTH (p2r_pkg::COLOR_W),
    .DEPTH (p2r_pkg::PAL_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (entry_index),
    .wdata (entry_color),
    .re    (pal_re),
    .raddr (pixel_byte),
    .rdata (pal_rdata)
  );

  // Row counters advance at accept; they do not depend on palette data
  always_comb begin
    col_nxt   = col_r;
    pads_nxt  = pads_r;
    fetch_nxt = fetch_r;
    if (em_load) begin
      fetch_nxt.valid = 1'b0;
    end
    if (in_acc && (in_tuser == p2r_pkg::MODE_PIXEL)) begin
      if (pads_r != 2'd0) begin
        // drop a source pad byte
        pads_nxt = pads_r - 2'd1;
      end else begin
        fetch_nxt.valid = 1'b1;
        if (row_end) begin
          col_nxt        = '0;
          pads_nxt       = 2'd0 - weff_r[1:0];
          fetch_nxt.npad = weff_r[1:0];
        end else begin
          col_nxt        = col_inc[CW-1:0];
          fetch_nxt.npad = 2'd0;
        end
      end
    end
  end

  // Emitter: hold the color and step through its bytes
  always_comb begin
    em_valid_nxt = em_valid_r;
    em_idx_nxt   = em_idx_r;
    em_last_nxt  = em_last_r;
    em_color_nxt = em_color_r;
    if (out_acc) begin
      em_idx_nxt = em_idx_r + 3'd1;
    end
    if (em_done) begin
      em_valid_nxt = 1'b0;
    end
    if (em_load) begin
      em_valid_nxt = 1'b1;
      em_idx_nxt   = p2r_pkg::POS_BLUE;
      em_last_nxt  = p2r_pkg::POS_RED + {1'b0, fetch_r.npad};
      em_color_nxt = pal_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weff_r     <= ONE_W;
      col_r      <= '0;
      pads_r     <= 2'd0;
      fetch_r    <= '0;
      em_valid_r <= 1'b0;
    end else begin
      weff_r     <= weff_nxt;
      col_r      <= col_nxt;
      pads_r     <= pads_nxt;
      fetch_r    <= fetch_nxt;
      em_valid_r <= em_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    em_idx_r     <= em_idx_nxt;
    em_last_r    <= em_last_nxt;
    em_color_r   <= em_color_nxt;
  end

  // Output byte select
  always_comb begin
    out_tuser = 1'b0;
    unique case (em_idx_r)
      p2r_pkg::POS_BLUE:  out_tdata = em_color_r[7:0];
      p2r_pkg::POS_GREEN: out_tdata = em_color_r[15:8];
      p2r_pkg::POS_RED:   out_tdata = em_color_r[23:16];
      default: begin
        out_tdata = p2r_pkg::PAD_BYTE;
        out_tuser = 1'b1;
      end
    endcase
  end

  assign out_tvalid = em_valid_r;
  assign out_tlast  = em_idx_r == em_last_r;

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    em_valid_r |-> (em_idx_r <= em_last_r))
    else $error("emitter index past last byte");

  a_last_after_red: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (em_idx_r >= p2r_pkg::POS_RED))
    else $error("run ended before all color bytes");

  a_drop_at_row_start: assert property (@(posedge clk) disable iff (!rst_n)
    (pads_r != 2'd0) |-> (col_r == '0))
    else $error("source pads pending mid-row");

  a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
    (weff_r != '0) && (weff_r <= MAX_W))
    else $error("effective width out of range");

endmodule

// ===== hw/rtl/p2r_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module p2r_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
